@@ rtl/sqlts_pkg.sv @@
// types, constants and keyword table for the sql token scanner
package sqlts_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_GT      = 4'd1,
        MODE_LT      = 4'd2,
        MODE_MINUS   = 4'd3,
        MODE_PLUS    = 4'd4,
        MODE_NUM     = 4'd5,
        MODE_STR     = 4'd6,
        MODE_WORD    = 4'd7,
        MODE_COMMENT = 4'd8
    } scan_mode_t;

    localparam logic [5:0] K_EOS     = 6'd0;
    localparam logic [5:0] K_SEMI    = 6'd1;
    localparam logic [5:0] K_LPAREN  = 6'd2;
    localparam logic [5:0] K_RPAREN  = 6'd3;
    localparam logic [5:0] K_STAR    = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_HASH    = 6'd6;
    localparam logic [5:0] K_COMMA   = 6'd7;
    localparam logic [5:0] K_EQ      = 6'd8;
    localparam logic [5:0] K_GT      = 6'd9;
    localparam logic [5:0] K_GTE     = 6'd10;
    localparam logic [5:0] K_LT      = 6'd11;
    localparam logic [5:0] K_LTE     = 6'd12;
    localparam logic [5:0] K_NE      = 6'd13;
    localparam logic [5:0] K_INT     = 6'd14;
    localparam logic [5:0] K_REAL    = 6'd15;
    localparam logic [5:0] K_STR     = 6'd16;
    localparam logic [5:0] K_IDENT   = 6'd17;
    localparam logic [5:0] K_UNKNOWN = 6'd18;
    localparam logic [5:0] K_KEYW0   = 6'd19;

    localparam int KW_SLOTS   = 32;
    localparam int KW_TXT_LEN = 16;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic [15:0] token_length;
        logic [7:0]  char_value;
        logic        last_of_run;
    } out_beat_t;

    // a token before flushing: line filled in by the caller
    typedef struct packed {
        logic        valid;
        logic [5:0]  kind;
        logic [15:0] column;
        logic [15:0] length;
        logic [7:0]  chv;
    } tok_t;

    function automatic logic [4:0] kw_len(input int idx);
        logic [4:0] r;
        case (idx)
            0, 1, 14, 15, 19, 20: r = 5'd3;
            2, 16:                r = 5'd2;
            3, 7, 13, 17, 21, 24: r = 5'd5;
            4, 8, 18, 22, 23:     r = 5'd6;
            5, 6, 10, 11, 12:     r = 5'd4;
            9:                    r = 5'd9;
            default:              r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8*KW_TXT_LEN-1:0] kw_txt(input int idx);
        logic [8*KW_TXT_LEN-1:0] r;
        r = '0;
        case (idx)
            0:  r[8*3-1:0] = {"c", "s", "a"};
            1:  r[8*3-1:0] = {"g", "v", "a"};
            2:  r[8*2-1:0] = {"y", "b"};
            3:  r[8*5-1:0] = {"t", "n", "u", "o", "c"};
            4:  r[8*6-1:0] = {"e", "t", "e", "l", "e", "d"};
            5:  r[8*4-1:0] = {"c", "s", "e", "d"};
            6:  r[8*4-1:0] = {"m", "o", "r", "f"};
            7:  r[8*5-1:0] = {"r", "e", "n", "n", "i"};
            8:  r[8*6-1:0] = {"t", "r", "e", "s", "n", "i"};
            9:  r[8*9-1:0] = {"t", "c", "e", "s", "r", "e", "t", "n", "i"};
            10: r[8*4-1:0] = {"o", "t", "n", "i"};
            11: r[8*4-1:0] = {"n", "i", "o", "j"};
            12: r[8*4-1:0] = {"e", "k", "i", "l"};
            13: r[8*5-1:0] = {"t", "i", "m", "i", "l"};
            14: r[8*3-1:0] = {"x", "a", "m"};
            15: r[8*3-1:0] = {"n", "i", "m"};
            16: r[8*2-1:0] = {"n", "o"};
            17: r[8*5-1:0] = {"r", "e", "d", "r", "o"};
            18: r[8*6-1:0] = {"t", "c", "e", "l", "e", "s"};
            19: r[8*3-1:0] = {"t", "e", "s"};
            20: r[8*3-1:0] = {"m", "u", "s"};
            21: r[8*5-1:0] = {"n", "o", "i", "n", "u"};
            22: r[8*6-1:0] = {"e", "t", "a", "d", "p", "u"};
            23: r[8*6-1:0] = {"s", "e", "u", "l", "a", "v"};
            24: r[8*5-1:0] = {"e", "r", "e", "h", "w"};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

endpackage

@@ rtl/sqlts_kw_match.sv @@
// parallel keyword compare of the word buffer
module sqlts_kw_match #(
    parameter int KEYWORD_COUNT   = 25,
    parameter int KEYWORD_MAX_LEN = 9
) (
    input  logic [KEYWORD_MAX_LEN-1:0][7:0] word,
    input  logic [15:0]                     word_len,
    input  logic                            too_long,
    output logic [5:0]                      kind
);
    logic [KEYWORD_COUNT-1:0] hit;

    always_comb begin
        logic [8*sqlts_pkg::KW_TXT_LEN-1:0] txt;
        logic [4:0]                         kl;
        logic                               eq;
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
            txt = sqlts_pkg::kw_txt(i);
            kl  = sqlts_pkg::kw_len(i);
            eq  = (kl != 5'd0) && ({11'd0, kl} == word_len)
                  && (int'(kl) <= KEYWORD_MAX_LEN);
            for (int j = 0; j < KEYWORD_MAX_LEN; j++) begin
                if ((j < int'(kl)) && (j < sqlts_pkg::KW_TXT_LEN)) begin
                    if (word[j] != txt[8*(j % sqlts_pkg::KW_TXT_LEN) +: 8]) begin
                        eq = 1'b0;
                    end
                end
            end
            hit[i] = eq;
        end
    end

    always_comb begin
        kind = sqlts_pkg::K_IDENT;
        if (!too_long && (word_len <= 16'(KEYWORD_MAX_LEN))) begin
            for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
                if (hit[i]) begin
                    kind = sqlts_pkg::K_KEYW0 + 6'(i);
                end
            end
        end
    end
endmodule

@@ rtl/sqlts_out_queue.sv @@
// two-entry result queue that drains one token per beat
module sqlts_out_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  sqlts_pkg::out_beat_t  tok_a,
    input  logic                  tok_a_vld,
    input  sqlts_pkg::out_beat_t  tok_b,
    input  logic                  tok_b_vld,
    output logic                  can_load,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sqlts_pkg::out_beat_t  m_data
);
    sqlts_pkg::out_beat_t ent_reg [2];
    logic [1:0]           cnt_reg, cnt_next;
    logic                 pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (cnt_reg != 2'd0);
    assign m_data   = ent_reg[0];
    // accept when the queue will be empty after this beat
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);

    always_comb begin
        cnt_next = cnt_reg;
        if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
        if (load) begin
            cnt_next = 2'(tok_a_vld) + 2'(tok_b_vld);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        if (load) begin
            ent_reg[0] <= tok_a_vld ? tok_a : tok_b;
            ent_reg[1] <= tok_b;
        end else if (pop) begin
            ent_reg[0] <= ent_reg[1];
        end
    end

`ifndef ASSERT_OFF
    a_no_load_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load) else $error("load into busy queue");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !ent_reg[0].last_of_run) else $error("last flag on first of two");
`endif
endmodule

@@ rtl/sql_token_scanner_core.sv @@
// top level of the sql token scanner
// The scanner takes one source byte per beat (or an end-of-input beat) and
// returns zero, one or two token beats for it; last_of_run marks the final
// token of each input beat. Each byte is decoded combinationally from the
// scanner state registers and its tokens land in a two-entry result queue,
// so one byte per cycle is accepted while the result side takes every beat
// at once; when a byte yields two tokens the input pauses while the queue
// drains. Keywords are matched by a parallel compare of the
// folded word buffer. Line and column counters saturate at COUNTER_BITS
// ones and lengths at 65535. An end-of-input beat flushes the pending
// token, emits end-of-stream and returns the scanner to its reset state.
module sql_token_scanner_core #(
    parameter int KEYWORD_COUNT   = 25,
    parameter int KEYWORD_MAX_LEN = 9,
    parameter int COUNTER_BITS    = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sqlts_pkg::in_beat_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sqlts_pkg::out_beat_t m_data
);
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
    localparam logic [15:0]             LEN_MAX = 16'hFFFF;
    localparam logic [7:0] CH_DOLLAR = 8'h24, CH_SEMI = 8'h3b, CH_LP = 8'h28,
        CH_RP = 8'h29, CH_STAR = 8'h2a, CH_DOT = 8'h2e, CH_HASH = 8'h23,
        CH_COMMA = 8'h2c, CH_EQ = 8'h3d, CH_GT = 8'h3e, CH_LT = 8'h3c,
        CH_MINUS = 8'h2d, CH_PLUS = 8'h2b, CH_DQ = 8'h22, CH_SQ = 8'h27,
        CH_SP = 8'h20, CH_TAB = 8'h09, CH_CR = 8'h0d, CH_FF = 8'h0c,
        CH_NL = 8'h0a, CH_US = 8'h5f;

    // scanner state
    sqlts_pkg::scan_mode_t             mode_reg, mode_next;
    logic [COUNTER_BITS-1:0]           line_reg, line_next;
    logic [COUNTER_BITS-1:0]           col_reg, col_next;
    logic [COUNTER_BITS-1:0]           scol_reg, scol_next;
    logic [15:0]                       vlen_reg, vlen_next;
    logic                              dot_reg, dot_next;
    logic                              quote_reg, quote_next;
    logic                              long_reg, long_next;
    logic [KEYWORD_MAX_LEN-1:0][7:0]   word_reg, word_next;

    logic       accept, can_load;
    logic [7:0] c;
    logic [5:0] word_kind;

    sqlts_pkg::tok_t      t1, t2;
    logic [15:0]          t1_line, t2_line;
    sqlts_pkg::out_beat_t o1, o2;

    assign c      = s_data.byte_in;
    assign s_ready = can_load;
    assign accept = s_valid && s_ready;

    sqlts_kw_match #(
        .KEYWORD_COUNT   (KEYWORD_COUNT),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_kw (
        .word     (word_reg),
        .word_len (vlen_reg),
        .too_long (long_reg),
        .kind     (word_kind)
    );

    function automatic logic [COUNTER_BITS-1:0] cinc(input logic [COUNTER_BITS-1:0] v);
        return (v != CNT_MAX) ? v + 1'b1 : v;
    endfunction

    function automatic logic [15:0] linc(input logic [15:0] v);
        return (v != LEN_MAX) ? v + 16'd1 : v;
    endfunction

    always_comb begin
        logic                    fresh;
        logic [COUNTER_BITS-1:0] fcol;
        logic [5:0]              pk;
        logic [7:0]              lc;
        logic [COUNTER_BITS-1:0] fline;

        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        scol_next  = scol_reg;
        vlen_next  = vlen_reg;
        dot_next   = dot_reg;
        quote_next = quote_reg;
        long_next  = long_reg;
        word_next  = word_reg;
        t1         = '0;
        t2         = '0;
        t1_line    = 16'(line_reg);
        fresh      = 1'b0;
        fcol       = '0;
        fline      = line_reg;
        pk         = '0;
        lc         = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;

        // pending token flush
        t1.column = 16'(scol_reg);
        case (mode_reg)
            sqlts_pkg::MODE_GT:    begin t1.kind = sqlts_pkg::K_GT;  t1.length = 16'd1; end
            sqlts_pkg::MODE_LT:    begin t1.kind = sqlts_pkg::K_LT;  t1.length = 16'd1; end
            sqlts_pkg::MODE_MINUS: begin
                t1.kind = sqlts_pkg::K_UNKNOWN; t1.length = 16'd1; t1.chv = CH_MINUS;
            end
            sqlts_pkg::MODE_PLUS:  begin
                t1.kind = sqlts_pkg::K_UNKNOWN; t1.length = 16'd1; t1.chv = CH_PLUS;
            end
            sqlts_pkg::MODE_NUM:   begin
                t1.kind = dot_reg ? sqlts_pkg::K_REAL : sqlts_pkg::K_INT; t1.length = vlen_reg;
            end
            sqlts_pkg::MODE_STR:   begin t1.kind = sqlts_pkg::K_STR; t1.length = vlen_reg; end
            sqlts_pkg::MODE_WORD:  begin t1.kind = word_kind; t1.length = vlen_reg; end
            default: ;
        endcase
        pk = t1.kind;

        if (s_data.end_of_input) begin
            t1.valid = (mode_reg != sqlts_pkg::MODE_IDLE) && (mode_reg != sqlts_pkg::MODE_COMMENT);
            t2.valid  = 1'b1;
            t2.kind   = sqlts_pkg::K_EOS;
            t2.column = 16'(col_reg);
            t2.length = 16'd1;
            t2.chv    = 8'd0;
            mode_next  = sqlts_pkg::MODE_IDLE;
            line_next  = '0;
            col_next   = '0;
            scol_next  = '0;
            vlen_next  = '0;
            dot_next   = 1'b0;
            quote_next = 1'b0;
            long_next  = 1'b0;
        end else begin
            t1.valid = 1'b0;
            case (mode_reg)
                sqlts_pkg::MODE_GT: begin
                    if (c == CH_EQ) begin
                        col_next = cinc(col_reg);
                        t1 = '{1'b1, sqlts_pkg::K_GTE, 16'(scol_reg), 16'd2, 8'd0};
                        mode_next = sqlts_pkg::MODE_IDLE;
                    end else begin
                        t1.valid = 1'b1; fresh = 1'b1;
                    end
                end
                sqlts_pkg::MODE_LT: begin
                    if (c == CH_EQ || c == CH_GT) begin
                        col_next = cinc(col_reg);
                        t1 = '{1'b1, (c == CH_EQ) ? sqlts_pkg::K_LTE : sqlts_pkg::K_NE,
                               16'(scol_reg), 16'd2, 8'd0};
                        mode_next = sqlts_pkg::MODE_IDLE;
                    end else begin
                        t1.valid = 1'b1; fresh = 1'b1;
                    end
                end
                sqlts_pkg::MODE_MINUS, sqlts_pkg::MODE_PLUS: begin
                    if (mode_reg == sqlts_pkg::MODE_MINUS && c == CH_MINUS) begin
                        col_next  = cinc(col_reg);
                        mode_next = sqlts_pkg::MODE_COMMENT;
                    end else if (sqlts_pkg::is_digit(c)) begin
                        col_next  = cinc(col_reg);
                        mode_next = sqlts_pkg::MODE_NUM;
                        vlen_next = 16'd2;
                        dot_next  = 1'b0;
                    end else begin
                        t1.valid = 1'b1; fresh = 1'b1;
                    end
                end
                sqlts_pkg::MODE_NUM: begin
                    if (sqlts_pkg::is_digit(c) || c == CH_DOT) begin
                        col_next  = cinc(col_reg);
                        vlen_next = linc(vlen_reg);
                        if (c == CH_DOT) begin
                            dot_next = 1'b1;
                        end
                    end else begin
                        t1.valid = 1'b1; fresh = 1'b1;
                    end
                end
                sqlts_pkg::MODE_STR: begin
                    col_next = cinc(col_reg);
                    if (c == (quote_reg ? CH_SQ : CH_DQ)) begin
                        t1.valid  = 1'b1;
                        mode_next = sqlts_pkg::MODE_IDLE;
                    end else begin
                        vlen_next = linc(vlen_reg);
                    end
                end
                sqlts_pkg::MODE_WORD: begin
                    if (sqlts_pkg::is_alpha(c) || sqlts_pkg::is_digit(c) || c == CH_US) begin
                        col_next = cinc(col_reg);
                        if (vlen_reg < 16'(KEYWORD_MAX_LEN)) begin
                            word_next[vlen_reg[$clog2(KEYWORD_MAX_LEN)-1:0]] = lc;
                        end else begin
                            long_next = 1'b1;
                        end
                        vlen_next = linc(vlen_reg);
                    end else begin
                        t1.valid = 1'b1; fresh = 1'b1;
                    end
                end
                sqlts_pkg::MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        fresh = 1'b1;
                    end
                end
                default: fresh = 1'b1;
            endcase

            if (fresh) begin
                fline     = (line_reg == '0) ? COUNTER_BITS'(1) : line_reg;
                fcol      = cinc(col_reg);
                line_next = fline;
                col_next  = fcol;
                mode_next = sqlts_pkg::MODE_IDLE;
                t2.column = 16'(fcol);
                t2.length = 16'd1;
                t2.chv    = 8'd0;
                case (c)
                    CH_DOLLAR: begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_EOS; end
                    CH_SEMI:   begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_SEMI; end
                    CH_LP:     begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_LPAREN; end
                    CH_RP:     begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_RPAREN; end
                    CH_STAR:   begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_STAR; end
                    CH_DOT:    begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_DOT; end
                    CH_HASH:   begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_HASH; end
                    CH_COMMA:  begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_COMMA; end
                    CH_EQ:     begin t2.valid = 1'b1; t2.kind = sqlts_pkg::K_EQ; end
                    CH_GT:     begin mode_next = sqlts_pkg::MODE_GT;    scol_next = fcol; end
                    CH_LT:     begin mode_next = sqlts_pkg::MODE_LT;    scol_next = fcol; end
                    CH_MINUS:  begin mode_next = sqlts_pkg::MODE_MINUS; scol_next = fcol; end
                    CH_PLUS:   begin mode_next = sqlts_pkg::MODE_PLUS;  scol_next = fcol; end
                    CH_DQ, CH_SQ: begin
                        mode_next  = sqlts_pkg::MODE_STR;
                        quote_next = (c == CH_SQ);
                        scol_next  = fcol;
                        vlen_next  = 16'd0;
                    end
                    CH_SP, CH_TAB, CH_CR, CH_FF: ;
                    CH_NL: begin
                        line_next = cinc(fline);
                        col_next  = '0;
                    end
                    default: begin
                        if (sqlts_pkg::is_digit(c)) begin
                            mode_next = sqlts_pkg::MODE_NUM;
                            scol_next = fcol;
                            vlen_next = 16'd1;
                            dot_next  = 1'b0;
                        end else if (sqlts_pkg::is_alpha(c)) begin
                            mode_next = sqlts_pkg::MODE_WORD;
                            scol_next = fcol;
                            vlen_next = 16'd1;
                            long_next = 1'b0;
                            word_next[0] = lc;
                        end else begin
                            t2.valid = 1'b1;
                            t2.kind  = sqlts_pkg::K_UNKNOWN;
                            t2.chv   = c;
                        end
                    end
                endcase
            end
        end
        // fresh tokens carry the line after the first-byte bump
        t2_line = s_data.end_of_input ? 16'(line_reg) : 16'(line_next);
        if (!t1.valid) begin
            t1.kind = pk;
        end
    end

    assign o1 = '{t1.kind, t1_line, t1.column, t1.length, t1.chv, !t2.valid};
    assign o2 = '{t2.kind, t2_line, t2.column, t2.length, t2.chv, 1'b1};

    sqlts_out_queue u_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .tok_a     (o1),
        .tok_a_vld (t1.valid),
        .tok_b     (o2),
        .tok_b_vld (t2.valid),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= sqlts_pkg::MODE_IDLE;
            line_reg  <= '0;
            col_reg   <= '0;
            scol_reg  <= '0;
            vlen_reg  <= '0;
            dot_reg   <= 1'b0;
            quote_reg <= 1'b0;
            long_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            scol_reg  <= scol_next;
            vlen_reg  <= vlen_next;
            dot_reg   <= dot_next;
            quote_reg <= quote_next;
            long_reg  <= long_next;
        end
        if (accept) begin
            word_reg <= word_next;
        end
    end

`ifndef ASSERT_OFF
    a_eoi_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_of_input) |=> (mode_reg == sqlts_pkg::MODE_IDLE && line_reg == '0))
        else $error("end of input did not reset scanner");
    a_eoi_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_of_input) |=> m_valid) else $error("no eos token");
    a_col_zero_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_reg == '0) |-> (col_reg == '0)) else $error("column without line");
`endif
endmodule
